// ===== sv/rpn_stack_evaluator_macros.svh =====
// Assertion macros shared by the RPN stack evaluator RTL.
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RPN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpn assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RPN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpn assertion failed");

`endif

// ===== sv/rpn_pkg.sv =====
// Types, codes and constants of the RPN stack evaluator.
package rpn_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned OP_W            = 3;
  localparam int unsigned LIT_W           = 31;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned DIV_STEPS       = DATA_W;
  localparam int unsigned DIV_CNT_W       = $clog2(DIV_STEPS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_FINISH = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ERR_NONE = 2'd0,
    ERR_FULL = 2'd1,
    ERR_FEW  = 2'd2,
    ERR_DIV0 = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_OPER,
    ST_DIVW,
    ST_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic push;
    logic alu_wr;
    logic div_start;
    logic div_wr;
    logic set_err;
    err_e err;
    logic load_out;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    err_e err;
    logic full;
    logic few;
    logic b_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/rpn_if.sv =====
// Token and result channel interfaces of the RPN stack evaluator.
interface rpn_in_if;
  logic                       valid;
  logic                       ready;
  logic [rpn_pkg::OP_W-1:0]   op;
  logic [rpn_pkg::LIT_W-1:0]  literal;

  modport source (output valid, output op, output literal, input ready);
  modport sink   (input valid, input op, input literal, output ready);
endinterface

interface rpn_out_if;
  logic                          valid;
  logic                          ready;
  logic [rpn_pkg::STATUS_W-1:0]  status;
  logic signed [rpn_pkg::DATA_W-1:0] value;
  logic                          final_res;

  modport source (output valid, output status, output value, output final_res, input ready);
  modport sink   (input valid, input status, input value, input final_res, output ready);
endinterface

// ===== sv/rpn_div.sv =====
// Radix-2 restoring divider, signed operands, truncating quotient.
module rpn_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rpn_pkg::DATA_W-1:0] dividend_i,
  input  logic [rpn_pkg::DATA_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [rpn_pkg::DATA_W-1:0] quotient_o
);
  import rpn_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]    quo_q, rem_q, mag_b_q;
  logic                 neg_q;
  logic [DATA_W:0]      trial;
  logic                 fits;

  // Shift in one dividend bit and try the subtract
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign fits  = trial >= {1'b0, mag_b_q};

  // Control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: take magnitudes on start, then one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q   <= dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
      mag_b_q <= divisor_i[DATA_W-1] ? (DATA_W'(0) - divisor_i) : divisor_i;
      neg_q   <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      rem_q   <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DATA_W'(trial - {1'b0, mag_b_q});
      end else begin
        rem_q <= trial[DATA_W-1:0];
      end
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

// ===== sv/rpn_dp.sv =====
// Datapath: operand stack, top-of-stack register, ALU, divider, result register.
module rpn_dp #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rpn_pkg::OP_W-1:0]      in_op_i,
  input  logic [rpn_pkg::LIT_W-1:0]     in_literal_i,
  input  rpn_pkg::cmd_t                 cmd_i,
  output rpn_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rpn_pkg::STATUS_W-1:0]  out_status_o,
  output logic [rpn_pkg::DATA_W-1:0]    out_value_o,
  output logic                          out_final_res_o
);
  import rpn_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  logic [OP_W-1:0]   op_q;
  logic [LIT_W-1:0]  lit_q;
  logic [CntW-1:0]   count_q, count_d, cnt_m1, cnt_m2;
  err_e              err_q, err_d;
  logic [DATA_W-1:0] tos_q, tos_d;
  // Entries below the top of stack; the top itself lives in tos_q
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] alu_r, div_q;
  logic              div_done, empty;
  logic              ov_q;
  err_e              ost_q, ost_d;
  logic [DATA_W-1:0] oval_q, oval_d;
  logic              ofin_q;

  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_q - CntW'(2);
  assign empty  = (count_q == '0);

  // Latch the token on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_op_i;
      lit_q <= in_literal_i;
    end
  end

  // Stack memory: spill old top on push, read the second entry every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !empty) begin
      mem[cnt_m1[AddrW-1:0]] <= tos_q;
    end
    rdata_q <= mem[cnt_m2[AddrW-1:0]];
  end

  // ALU on second entry (a) and top (b)
  always_comb begin
    case (op_e'(op_q))
      OP_ADD:  alu_r = rdata_q + tos_q;
      OP_SUB:  alu_r = rdata_q - tos_q;
      OP_MUL:  alu_r = rdata_q * tos_q;
      default: alu_r = rdata_q + tos_q;
    endcase
  end

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rdata_q),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Next stack state
  always_comb begin
    count_d = count_q;
    err_d   = err_q;
    tos_d   = tos_q;
    if (cmd_i.push) begin
      tos_d   = {1'b0, lit_q};
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.alu_wr) begin
      tos_d   = alu_r;
      count_d = cnt_m1;
    end
    if (cmd_i.div_wr) begin
      tos_d   = div_q;
      count_d = cnt_m1;
    end
    if (cmd_i.set_err) begin
      err_d = cmd_i.err;
    end
    if (cmd_i.load_out && cmd_i.finish) begin
      count_d = '0;
      err_d   = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      err_q   <= ERR_NONE;
    end else begin
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
  end

  // Build the result from the state before the finish clears it
  always_comb begin
    if (cmd_i.finish) begin
      if (err_q != ERR_NONE) begin
        ost_d  = err_q;
        oval_d = '0;
      end else if (empty) begin
        ost_d  = ERR_FEW;
        oval_d = '0;
      end else begin
        ost_d  = ERR_NONE;
        oval_d = tos_q;
      end
    end else begin
      ost_d  = err_q;
      oval_d = empty ? '0 : tos_q;
    end
  end

  // Result register: hold until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      ost_q  <= ost_d;
      oval_q <= oval_d;
      ofin_q <= cmd_i.finish;
    end
  end

  assign out_valid_o     = ov_q;
  assign out_status_o    = ost_q;
  assign out_value_o     = oval_q;
  assign out_final_res_o = ofin_q;

  // Status to the controller
  assign sts_o.op       = op_e'(op_q);
  assign sts_o.err      = err_q;
  assign sts_o.full     = (count_q == CntW'(STACK_DEPTH));
  assign sts_o.few      = (count_q < CntW'(2));
  assign sts_o.b_zero   = (tos_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ov_q || out_ready_i;

endmodule

// ===== sv/rpn_ctrl.sv =====
// Controller: sequences each token through decode, operate and divide as needed, and respond.
module rpn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rpn_pkg::sts_t sts_i,
  output rpn_pkg::cmd_t cmd_o
);
  import rpn_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_RESP;
        if (sts_i.op != OP_FINISH && sts_i.err == ERR_NONE) begin
          unique case (sts_i.op) inside
            OP_PUSH: begin
              if (sts_i.full) begin
                cmd_o.set_err = 1'b1;
                cmd_o.err     = ERR_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (sts_i.few) begin
                cmd_o.set_err = 1'b1;
                cmd_o.err     = ERR_FEW;
              end else begin
                state_d = ST_OPER;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_OPER: begin
        if (sts_i.op == OP_DIV) begin
          if (sts_i.b_zero) begin
            cmd_o.set_err = 1'b1;
            cmd_o.err     = ERR_DIV0;
            state_d       = ST_RESP;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIVW;
          end
        end else begin
          cmd_o.alu_wr = 1'b1;
          state_d      = ST_RESP;
        end
      end
      ST_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          state_d      = ST_RESP;
        end
      end
      ST_RESP: begin
        cmd_o.finish = (sts_i.op == OP_FINISH);
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/rpn_stack_evaluator.sv =====
// Top level of the RPN stack evaluator: controller, datapath and checks.
//
//   channel  dir  fields                        transfer
//   in_i     in   op[2:0] literal[30:0]         valid && ready
//   out_o    out  status[1:0] value[31:0]       valid && ready
//                 final_res
//
// Push, finish, unused codes and decode errors go from decode to respond; add,
// subtract and multiply pass through operate, divide also through the divide wait
// (a zero divisor ends in operate): the divider retires one quotient bit a cycle.
// The stack memory has one read port, used to fetch the second operand.
// Reset clears the count, the error and the control; stack contents stay
// undefined until written, so no clearing pass runs.
// A token is taken while the previous result still waits; the new result
// is held back until the result register is free.
module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpn_in_if.sink     in_i,
  rpn_out_if.source  out_o
);
  import rpn_pkg::*;

`include "rpn_stack_evaluator_macros.svh"

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] value;

  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_op_i         (in_i.op),
    .in_literal_i    (in_i.literal),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_status_o    (out_o.status),
    .out_value_o     (value),
    .out_final_res_o (out_o.final_res)
  );

  assign out_o.value = $signed(value);

  // Checks on controller decisions against datapath status
  `RPN_ASSERT_NOW(a_push_not_full, cmd.push, !sts.full)
  `RPN_ASSERT_NOW(a_pop_has_two, cmd.alu_wr || cmd.div_wr || cmd.div_start, !sts.few)
  `RPN_ASSERT_NOW(a_div_nonzero, cmd.div_start, !sts.b_zero)
  `RPN_ASSERT_NOW(a_load_when_free, cmd.load_out, sts.out_free)
  `RPN_ASSERT_NEXT(a_one_token, in_i.valid && in_i.ready, !in_i.ready)

endmodule
